[rtl/elfhv_pkg.sv]
// shared types, constants and status codes for the elf32 header validator
`timescale 1ns / 1ps

package elfhv_pkg;

  localparam int unsigned CFG_COUNT   = 4;
  localparam int unsigned CFG_IDX_W   = $clog2(CFG_COUNT);
  localparam int unsigned CFG_DATA_W  = 32;

  localparam logic [15:0] EHDR_BYTES  = 16'd52;
  localparam logic [15:0] PHDR_BYTES  = 16'd32;
  localparam logic [15:0] SHDR_BYTES  = 16'd40;
  localparam logic [31:0] ELF_MAGIC   = 32'h464C_457F;
  localparam logic [7:0]  IDENT_ONE   = 8'd1;
  localparam logic [15:0] TYPE_FIRST  = 16'd1;
  localparam logic [15:0] TYPE_LAST   = 16'd4;
  localparam logic [31:0] VERSION_MAX = 32'd1;

  typedef logic [CFG_IDX_W-1:0] cfg_index_t;

  localparam cfg_index_t CFG_MACH_A    = 2'd0;
  localparam cfg_index_t CFG_MACH_B    = 2'd1;
  localparam cfg_index_t CFG_MIN_BYTES = 2'd2;
  localparam cfg_index_t CFG_OS_FLOOR  = 2'd3;

  typedef logic [4:0] status_t;

  localparam status_t ST_OK          = 5'd0;
  localparam status_t ST_BAD_ARG     = 5'd1;
  localparam status_t ST_TOO_SMALL   = 5'd2;
  localparam status_t ST_NOT_ELF     = 5'd3;
  localparam status_t ST_BAD_IDVER   = 5'd4;
  localparam status_t ST_BAD_CLASS   = 5'd5;
  localparam status_t ST_UNSUPPORTED = 5'd6;
  localparam status_t ST_CORRUPTED   = 5'd7;
  localparam status_t ST_BAD_TYPE    = 5'd8;
  localparam status_t ST_BAD_PHENT   = 5'd9;
  localparam status_t ST_BAD_PHNUM   = 5'd10;
  localparam status_t ST_BAD_PHOFF   = 5'd11;
  localparam status_t ST_BAD_SHENT   = 5'd12;
  localparam status_t ST_BAD_SHNUM   = 5'd13;
  localparam status_t ST_BAD_SHOFF   = 5'd14;
  localparam status_t ST_BAD_STRNDX  = 5'd15;
  localparam status_t ST_OVERLAP     = 5'd16;

  typedef struct packed {
    logic [15:0] machine_code_a;
    logic [15:0] machine_code_b;
    logic [31:0] min_file_bytes;
    logic [15:0] os_type_floor;
  } cfg_t;

  typedef struct packed {
    logic [55:0] ident_bytes;
    logic [31:0] type_machine;
    logic [31:0] elf_version;
    logic [15:0] header_size;
    logic [31:0] ph_offset;
    logic [31:0] ph_table;
    logic [31:0] sh_start;
    logic [31:0] sh_table;
    logic [15:0] sh_string_index;
    logic [31:0] header_bytes;
    logic [31:0] file_size;
  } hdr_t;

  // what the header stage hands to the table stage
  typedef struct packed {
    status_t     pre_status;
    logic        ph_present;
    logic        sh_present;
    logic        ph_ent_bad;
    logic        sh_ent_bad;
    logic [31:0] ph_bytes;
    logic [31:0] sh_bytes;
    logic [31:0] ph_offset;
    logic [31:0] sh_start;
    logic [15:0] ehsize;
    logic [31:0] file_size;
    logic [15:0] str_index;
    logic [15:0] sh_count;
  } mid_t;

endpackage

[rtl/elfhv_if.sv]
// valid/ready channel interfaces for header transactions and status results
`timescale 1ns / 1ps

interface elfhv_in_if;
  logic        valid;
  logic        ready;
  logic [55:0] ident_bytes;
  logic [31:0] type_machine;
  logic [31:0] elf_version;
  logic [15:0] header_size;
  logic [31:0] ph_offset;
  logic [31:0] ph_table;
  logic [31:0] sh_start;
  logic [31:0] sh_table;
  logic [15:0] sh_string_index;
  logic [31:0] header_bytes;
  logic [31:0] file_size;

  modport source (
    output valid, ident_bytes, type_machine, elf_version, header_size, ph_offset,
    output ph_table, sh_start, sh_table, sh_string_index, header_bytes, file_size,
    input  ready
  );
  modport sink (
    input  valid, ident_bytes, type_machine, elf_version, header_size, ph_offset,
    input  ph_table, sh_start, sh_table, sh_string_index, header_bytes, file_size,
    output ready
  );
endinterface

interface elfhv_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] status;

  modport source (output valid, status, input ready);
  modport sink (input valid, status, output ready);
endinterface

[rtl/elfhv_cfg_regs.sv]
// configuration registers with their reset values
`timescale 1ns / 1ps

module elfhv_cfg_regs (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    wr_en,
  input  elfhv_pkg::cfg_index_t   wr_index,
  input  logic [31:0]             wr_data,
  output elfhv_pkg::cfg_t         cfg
);
  import elfhv_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.machine_code_a <= 16'd3;
      cfg.machine_code_b <= 16'd40;
      cfg.min_file_bytes <= 32'd52;
      cfg.os_type_floor  <= 16'hFE00;
    end else if (wr_en) begin
      case (wr_index)
        CFG_MACH_A:    cfg.machine_code_a <= wr_data[15:0];
        CFG_MACH_B:    cfg.machine_code_b <= wr_data[15:0];
        CFG_MIN_BYTES: cfg.min_file_bytes <= wr_data;
        CFG_OS_FLOOR:  cfg.os_type_floor  <= wr_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/elfhv_hdr_check.sv]
// first stage: identification and header checks, table byte counts
`timescale 1ns / 1ps

module elfhv_hdr_check (
  input  elfhv_pkg::hdr_t  hdr,
  input  elfhv_pkg::cfg_t  cfg,
  output elfhv_pkg::mid_t  mid
);
  import elfhv_pkg::*;

  logic [15:0] ftype;
  logic [15:0] mach;
  logic [15:0] ph_ent;
  logic [15:0] ph_num;
  logic [15:0] sh_ent;
  logic [15:0] sh_num;
  logic [15:0] ph_ent_eff;
  logic [15:0] sh_ent_eff;
  logic [15:0] ehsize_eff;
  logic        type_bad;
  status_t     pre;

  assign ftype  = hdr.type_machine[15:0];
  assign mach   = hdr.type_machine[31:16];
  assign ph_ent = hdr.ph_table[15:0];
  assign ph_num = hdr.ph_table[31:16];
  assign sh_ent = hdr.sh_table[15:0];
  assign sh_num = hdr.sh_table[31:16];

  assign ph_ent_eff = (ph_ent == 16'd0) ? PHDR_BYTES : ph_ent;
  assign sh_ent_eff = (sh_ent == 16'd0) ? SHDR_BYTES : sh_ent;
  assign ehsize_eff = (hdr.header_size == 16'd0) ? EHDR_BYTES : hdr.header_size;

  // os specific types at or above the floor pass
  assign type_bad = ((ftype < TYPE_FIRST) || (ftype > TYPE_LAST)) &&
                    (ftype < cfg.os_type_floor);

  always_comb begin
    if (hdr.header_bytes > hdr.file_size)
      pre = ST_BAD_ARG;
    else if ((hdr.header_bytes < {16'd0, EHDR_BYTES}) ||
             (hdr.file_size < cfg.min_file_bytes))
      pre = ST_TOO_SMALL;
    else if (hdr.ident_bytes[31:0] != ELF_MAGIC)
      pre = ST_NOT_ELF;
    else if (hdr.ident_bytes[55:48] != IDENT_ONE)
      pre = ST_BAD_IDVER;
    else if (hdr.ident_bytes[39:32] != IDENT_ONE)
      pre = ST_BAD_CLASS;
    else if (hdr.ident_bytes[47:40] != IDENT_ONE)
      pre = ST_UNSUPPORTED;
    else if ((hdr.header_size != 16'd0) && (hdr.header_size < EHDR_BYTES))
      pre = ST_CORRUPTED;
    else if (hdr.header_bytes < {16'd0, ehsize_eff})
      pre = ST_TOO_SMALL;
    else if (type_bad)
      pre = ST_BAD_TYPE;
    else if (hdr.elf_version > VERSION_MAX)
      pre = ST_UNSUPPORTED;
    else if ((mach != cfg.machine_code_a) && (mach != cfg.machine_code_b))
      pre = ST_UNSUPPORTED;
    else
      pre = ST_OK;
  end

  always_comb begin
    mid.pre_status = pre;
    mid.ph_present = (ph_num != 16'd0);
    mid.sh_present = (sh_num != 16'd0);
    mid.ph_ent_bad = (ph_ent != 16'd0) && (ph_ent < PHDR_BYTES);
    mid.sh_ent_bad = (sh_ent != 16'd0) && (sh_ent < SHDR_BYTES);
    mid.ph_bytes   = {16'd0, ph_num} * {16'd0, ph_ent_eff};
    mid.sh_bytes   = {16'd0, sh_num} * {16'd0, sh_ent_eff};
    mid.ph_offset  = hdr.ph_offset;
    mid.sh_start   = hdr.sh_start;
    mid.ehsize     = ehsize_eff;
    mid.file_size  = hdr.file_size;
    mid.str_index  = hdr.sh_string_index;
    mid.sh_count   = sh_num;
  end

endmodule

[rtl/elfhv_tbl_check.sv]
// second stage: table bounds, string index and overlap, final status select
`timescale 1ns / 1ps

module elfhv_tbl_check (
  input  elfhv_pkg::mid_t    mid,
  output elfhv_pkg::status_t status
);
  import elfhv_pkg::*;

  status_t ph_st;
  status_t sh_st;
  logic    strx_bad;
  logic    overlap;

  always_comb begin
    if (!mid.ph_present)
      ph_st = (mid.ph_offset != 32'd0) ? ST_CORRUPTED : ST_OK;
    else if (mid.ph_ent_bad)
      ph_st = ST_BAD_PHENT;
    else if (mid.ph_bytes > mid.file_size)
      ph_st = ST_BAD_PHNUM;
    else if ((mid.ph_offset < {16'd0, mid.ehsize}) ||
             (mid.ph_offset > (mid.file_size - mid.ph_bytes)))
      ph_st = ST_BAD_PHOFF;
    else
      ph_st = ST_OK;
  end

  always_comb begin
    if (!mid.sh_present)
      sh_st = ((mid.sh_start != 32'd0) || (mid.str_index != 16'd0)) ?
              ST_CORRUPTED : ST_OK;
    else if (mid.sh_ent_bad)
      sh_st = ST_BAD_SHENT;
    else if (mid.sh_bytes > mid.file_size)
      sh_st = ST_BAD_SHNUM;
    else if ((mid.sh_start < {16'd0, mid.ehsize}) ||
             (mid.sh_start > (mid.file_size - mid.sh_bytes)))
      sh_st = ST_BAD_SHOFF;
    else
      sh_st = ST_OK;
  end

  assign strx_bad = (mid.str_index != 16'd0) && (mid.str_index >= mid.sh_count);

  // lower table must end before the other starts; ties go to the section table
  always_comb begin
    if (!(mid.ph_present && mid.sh_present))
      overlap = 1'b0;
    else if (mid.ph_offset < mid.sh_start)
      overlap = ({1'b0, mid.ph_offset} + {1'b0, mid.ph_bytes}) > {1'b0, mid.sh_start};
    else
      overlap = ({1'b0, mid.sh_start} + {1'b0, mid.sh_bytes}) > {1'b0, mid.ph_offset};
  end

  always_comb begin
    if (mid.pre_status != ST_OK)
      status = mid.pre_status;
    else if (ph_st != ST_OK)
      status = ph_st;
    else if (sh_st != ST_OK)
      status = sh_st;
    else if (strx_bad)
      status = ST_BAD_STRNDX;
    else if (overlap)
      status = ST_OVERLAP;
    else
      status = ST_OK;
  end

endmodule

[rtl/elf32_header_validator_unit.sv]
// top level of the elf32 header validator: pipeline registers and handshake
`timescale 1ns / 1ps

// Checks one 32-bit little-endian ELF file header per transaction and returns
// a single status code: 0 when every check passes, otherwise the first check
// that fails in the validator's priority order.
// in_ch carries the header fields plus the available header bytes and the file
// size; out_ch carries the 5-bit status. Both use valid/ready.
// Configuration (accepted machine codes, minimum file size, OS type floor) is
// written through wr_en / wr_index / wr_data; the user must do so only while
// the block is idle, as the block itself does not enforce it. Pipeline: input
// register, header stage with the two 16x16 table multiplies, table stage
// register, output register; one transaction per cycle while out_ch is ready.
// Reset empties the pipeline and loads the default configuration.
// When out_ch stalls, items stay in place and in_ch.ready drops once the
// three registers are full; nothing is dropped or repeated.
module elf32_header_validator_unit (
  input  logic                  clk,
  input  logic                  rst,
  elfhv_in_if.sink              in_ch,
  elfhv_out_if.source           out_ch,
  input  logic                  wr_en,
  input  elfhv_pkg::cfg_index_t wr_index,
  input  logic [31:0]           wr_data
);
  import elfhv_pkg::*;

  cfg_t    cfg;
  hdr_t    hdr_in;
  hdr_t    s0;
  mid_t    mid_next;
  mid_t    s1;
  status_t status_next;
  status_t status;
  logic    v0;
  logic    v1;
  logic    v2;
  logic    adv0;
  logic    adv1;
  logic    adv2;

  elfhv_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  elfhv_hdr_check u_hdr (
    .hdr (s0),
    .cfg (cfg),
    .mid (mid_next)
  );

  elfhv_tbl_check u_tbl (
    .mid    (s1),
    .status (status_next)
  );

  always_comb begin
    hdr_in.ident_bytes     = in_ch.ident_bytes;
    hdr_in.type_machine    = in_ch.type_machine;
    hdr_in.elf_version     = in_ch.elf_version;
    hdr_in.header_size     = in_ch.header_size;
    hdr_in.ph_offset       = in_ch.ph_offset;
    hdr_in.ph_table        = in_ch.ph_table;
    hdr_in.sh_start        = in_ch.sh_start;
    hdr_in.sh_table        = in_ch.sh_table;
    hdr_in.sh_string_index = in_ch.sh_string_index;
    hdr_in.header_bytes    = in_ch.header_bytes;
    hdr_in.file_size       = in_ch.file_size;
  end

  // each stage moves when the one after it is empty or moving
  assign adv2 = !v2 || out_ch.ready;
  assign adv1 = !v1 || adv2;
  assign adv0 = !v0 || adv1;

  assign in_ch.ready  = adv0;
  assign out_ch.valid = v2;
  assign out_ch.status = status;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (adv0) v0 <= in_ch.valid;
      if (adv1) v1 <= v0;
      if (adv2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv0 && in_ch.valid) s0 <= hdr_in;
    if (adv1 && v0)          s1 <= mid_next;
    if (adv2 && v1)          status <= status_next;
  end

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.status <= ST_OVERLAP))
    else $error("status code out of range");

  a_early_fail_kept: assert property (@(posedge clk) disable iff (rst)
    (v1 && adv2 && (s1.pre_status != ST_OK)) |=> (out_ch.status == $past(s1.pre_status)))
    else $error("early check result lost in table stage");

  a_reset_flush: assert property (@(posedge clk)
    rst |=> (!v0 && !v1 && !out_ch.valid))
    else $error("pipeline not empty after reset");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !v0 |-> in_ch.ready)
    else $error("input stalled with empty input register");

endmodule

[tb/sv/tb_elf32_header_validator_unit.sv]
// self-checking testbench for the elf32 header validator unit
`timescale 1ns / 1ps

module tb_elf32_header_validator_unit;
  import elfhv_pkg::*;

  localparam int unsigned HDR_W     = $bits(hdr_t);
  localparam int unsigned IDENT_LSB = HDR_W - 56;

  typedef enum {
    PR_SOUND, PR_ARG, PR_SHORT_HDR, PR_SHORT_FILE, PR_MAGIC, PR_IDVER, PR_CLASS,
    PR_DATA, PR_EHSIZE_LOW, PR_EHSIZE_HIGH, PR_TYPE, PR_TYPE_OS, PR_VERSION,
    PR_MACHINE, PR_PH_EMPTY, PR_SH_EMPTY, PR_PHENT, PR_PHNUM, PR_PHOFF, PR_SHENT,
    PR_SHNUM, PR_SHOFF, PR_STRNDX, PR_OVERLAP, PR_ZEROS, PR_ONES, PR_COUNT
  } probe_t;

  typedef enum {HIT_BIT, HIT_NUDGE, HIT_CHUNK, HIT_IDENT} hit_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        wr_en;
  cfg_index_t  wr_index;
  logic [31:0] wr_data;

  elfhv_in_if  in_ch();
  elfhv_out_if out_ch();

  elf32_header_validator_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  cfg_t        model_cfg;
  hdr_t        pending_hdrs[$];
  status_t     expected_status[$];
  hdr_t        on_wire;
  status_t     oldest_status;
  int unsigned mismatch_count = 0;
  int unsigned send_gap_pct   = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned gap_by_phase[4]   = '{0, 54, 0, 37};
  int unsigned stall_by_phase[4] = '{0, 0, 54, 37};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic status_t table_fault(logic [15:0] count, logic [15:0] ent,
                                          logic [15:0] std_size, logic [31:0] off,
                                          logic [15:0] ehsize, logic [31:0] fsize,
                                          status_t e_ent, status_t e_cnt,
                                          status_t e_off);
    logic [63:0] span;
    span = 64'(count) * 64'((ent != 16'd0) ? ent : std_size);
    if (ent != 16'd0 && ent < std_size) return e_ent;
    if (span > 64'(fsize)) return e_cnt;
    if (off < 32'(ehsize) || 64'(off) > 64'(fsize) - span) return e_off;
    return ST_OK;
  endfunction

  function automatic status_t header_status(hdr_t h);
    logic [15:0] ftype, mach, ehsize, phent, phnum, shent, shnum, strx;
    logic [63:0] span;
    status_t     st;
    ftype  = h.type_machine[15:0];
    mach   = h.type_machine[31:16];
    phent  = h.ph_table[15:0];
    phnum  = h.ph_table[31:16];
    shent  = h.sh_table[15:0];
    shnum  = h.sh_table[31:16];
    strx   = h.sh_string_index;
    ehsize = h.header_size;

    if (h.header_bytes > h.file_size) return ST_BAD_ARG;
    if (h.header_bytes < 32'(EHDR_BYTES) || h.file_size < model_cfg.min_file_bytes)
      return ST_TOO_SMALL;
    if (h.ident_bytes[31:0] != ELF_MAGIC) return ST_NOT_ELF;
    if (h.ident_bytes[55:48] != IDENT_ONE) return ST_BAD_IDVER;
    if (h.ident_bytes[39:32] != IDENT_ONE) return ST_BAD_CLASS;
    if (h.ident_bytes[47:40] != IDENT_ONE) return ST_UNSUPPORTED;

    if (ehsize == 16'd0) begin
      ehsize = EHDR_BYTES;
    end else if (ehsize < EHDR_BYTES) begin
      return ST_CORRUPTED;
    end
    if (h.header_bytes < 32'(ehsize)) return ST_TOO_SMALL;

    if ((ftype < TYPE_FIRST || ftype > TYPE_LAST) && ftype < model_cfg.os_type_floor)
      return ST_BAD_TYPE;
    if (h.elf_version > VERSION_MAX) return ST_UNSUPPORTED;
    if (mach != model_cfg.machine_code_a && mach != model_cfg.machine_code_b)
      return ST_UNSUPPORTED;

    if (phnum != 16'd0) begin
      st = table_fault(phnum, phent, PHDR_BYTES, h.ph_offset, ehsize, h.file_size,
                       ST_BAD_PHENT, ST_BAD_PHNUM, ST_BAD_PHOFF);
      if (st != ST_OK) return st;
    end else if (h.ph_offset != 32'd0) begin
      return ST_CORRUPTED;
    end

    if (shnum != 16'd0) begin
      st = table_fault(shnum, shent, SHDR_BYTES, h.sh_start, ehsize, h.file_size,
                       ST_BAD_SHENT, ST_BAD_SHNUM, ST_BAD_SHOFF);
      if (st != ST_OK) return st;
    end else if (h.sh_start != 32'd0 || strx != 16'd0) begin
      return ST_CORRUPTED;
    end

    if (strx != 16'd0 && strx >= shnum) return ST_BAD_STRNDX;

    // equal offsets count the section table as the lower one
    if (phnum != 16'd0 && shnum != 16'd0) begin
      if (h.ph_offset < h.sh_start) begin
        span = 64'(phnum) * 64'((phent != 16'd0) ? phent : PHDR_BYTES);
        if (64'(h.ph_offset) + span > 64'(h.sh_start)) return ST_OVERLAP;
      end else begin
        span = 64'(shnum) * 64'((shent != 16'd0) ? shent : SHDR_BYTES);
        if (64'(h.sh_start) + span > 64'(h.ph_offset)) return ST_OVERLAP;
      end
    end
    return ST_OK;
  endfunction

  // ---------------------------------------------------------------- stimulus

  // a header that passes every check under the current configuration,
  // unless the two tables are asked to overlap
  function automatic hdr_t sound_header(bit both_tables, bit overlap);
    hdr_t        h;
    logic [15:0] hsize, eff, phnum, shnum, phent, shent, ftype, mach, strx;
    logic [63:0] ph_span, sh_span, a_span, b_span, a_at, b_at, end_pos, fsize;
    bit          sh_first;
    hsize = ($urandom_range(3) == 0) ? 16'd0 : 16'(EHDR_BYTES + $urandom_range(16));
    eff   = (hsize == 16'd0) ? EHDR_BYTES : hsize;
    phnum = (both_tables || $urandom_range(3) != 0) ? 16'($urandom_range(8, 1)) : 16'd0;
    shnum = (both_tables || $urandom_range(3) != 0) ? 16'($urandom_range(8, 1)) : 16'd0;
    phent = ($urandom_range(2) == 0) ? 16'd0 : 16'($urandom_range(64, 32));
    shent = ($urandom_range(2) == 0) ? 16'd0 : 16'($urandom_range(72, 40));
    ph_span = 64'(phnum) * 64'((phent != 16'd0) ? phent : PHDR_BYTES);
    sh_span = 64'(shnum) * 64'((shent != 16'd0) ? shent : SHDR_BYTES);

    sh_first = 1'($urandom_range(1));
    a_span = sh_first ? sh_span : ph_span;
    b_span = sh_first ? ph_span : sh_span;
    a_at = 64'(eff) + (($urandom_range(1) == 0) ? 64'd0 : 64'($urandom_range(24)));
    if (overlap && a_span != 64'd0 && b_span != 64'd0)
      b_at = a_at + 64'($urandom_range(32'(a_span) - 1));
    else
      b_at = a_at + a_span + (($urandom_range(1) == 0) ? 64'd0 : 64'($urandom_range(16)));
    end_pos = (a_at + a_span > b_at + b_span) ? a_at + a_span : b_at + b_span;

    // tight fits are common so that a nudge lands right on a bound
    fsize = end_pos + (($urandom_range(3) == 0) ? 64'd0 : 64'($urandom_range(64)));
    if (fsize < 64'(eff) + 64'd32) fsize = 64'(eff) + 64'd32;
    if (fsize < 64'(model_cfg.min_file_bytes)) fsize = 64'(model_cfg.min_file_bytes);

    if ($urandom_range(3) == 0)
      ftype = 16'($urandom_range(65535, 32'(model_cfg.os_type_floor)));
    else
      ftype = 16'($urandom_range(4, 1));
    mach = ($urandom_range(1) == 0) ? model_cfg.machine_code_a : model_cfg.machine_code_b;
    strx = (shnum != 16'd0 && $urandom_range(1) == 1) ?
           16'($urandom_range(32'(shnum) - 1)) : 16'd0;

    h.ident_bytes     = {IDENT_ONE, IDENT_ONE, IDENT_ONE, ELF_MAGIC};
    h.type_machine    = {mach, ftype};
    h.elf_version     = 32'($urandom_range(1));
    h.header_size     = hsize;
    h.ph_offset       = (phnum == 16'd0) ? 32'd0 : (sh_first ? b_at[31:0] : a_at[31:0]);
    h.ph_table        = {phnum, phent};
    h.sh_start        = (shnum == 16'd0) ? 32'd0 : (sh_first ? a_at[31:0] : b_at[31:0]);
    h.sh_table        = {shnum, shent};
    h.sh_string_index = strx;
    h.header_bytes    = 32'(eff) + 32'($urandom_range(32));
    h.file_size       = fsize[31:0];
    return h;
  endfunction

  // breaks one spot of a header: one bit, a small step, a 16-bit word or an ident byte
  function automatic hdr_t damage(hdr_t h);
    logic [HDR_W-1:0] v;
    logic [15:0]      w;
    int unsigned      k, pos, pick;
    v    = h;
    k    = $urandom_range(IDENT_LSB / 16 - 1);
    pick = $urandom_range(3);
    case (hit_t'($urandom_range(3)))
      HIT_BIT: begin
        pos = $urandom_range(HDR_W - 1);
        v[pos] = ~v[pos];
      end
      HIT_NUDGE: begin
        w = v[16*k +: 16];
        if ($urandom_range(1) == 0) w = w + 16'($urandom_range(3, 1));
        else w = w - 16'($urandom_range(3, 1));
        v[16*k +: 16] = w;
      end
      HIT_CHUNK: begin
        if (pick == 0) w = 16'd0;
        else if (pick == 1) w = 16'($urandom_range(63));
        else if (pick == 2) w = 16'hFFFF;
        else w = 16'($urandom());
        v[16*k +: 16] = w;
      end
      default: begin
        pos = IDENT_LSB + 8 * $urandom_range(6);
        v[pos +: 8] = (pick < 3) ? 8'(pick) : 8'($urandom());
      end
    endcase
    return hdr_t'(v);
  endfunction

  function automatic hdr_t noise_header();
    hdr_t        h;
    logic [351:0] raw;
    logic [31:0]  t;
    for (int i = 0; i < 11; i++) raw[32*i +: 32] = $urandom();
    h = hdr_t'(raw[HDR_W-1:0]);
    if ($urandom_range(1) == 0 && h.header_bytes > h.file_size) begin
      t = h.header_bytes;
      h.header_bytes = h.file_size;
      h.file_size = t;
    end
    return h;
  endfunction

  function automatic hdr_t probe_header(probe_t p);
    hdr_t        h;
    logic [15:0] eff;
    h   = sound_header(1'b1, p == PR_OVERLAP);
    eff = (h.header_size == 16'd0) ? EHDR_BYTES : h.header_size;
    case (p)
      PR_ARG:         h.header_bytes = h.file_size + 32'd1;
      PR_SHORT_HDR:   h.header_bytes = 32'(EHDR_BYTES) - 32'd1;
      PR_SHORT_FILE: begin
        h.file_size    = model_cfg.min_file_bytes - 32'd1;
        h.header_bytes = h.file_size;
      end
      PR_MAGIC:       h.ident_bytes[7:0] = 8'h7E;
      PR_IDVER:       h.ident_bytes[55:48] = 8'd0;
      PR_CLASS:       h.ident_bytes[39:32] = 8'd2;
      PR_DATA:        h.ident_bytes[47:40] = 8'd2;
      PR_EHSIZE_LOW:  h.header_size = EHDR_BYTES - 16'd1;
      PR_EHSIZE_HIGH: h.header_size = 16'(h.header_bytes + 32'd1);
      PR_TYPE:        h.type_machine[15:0] = 16'd0;
      PR_TYPE_OS:     h.type_machine[15:0] = 16'hFFFF;
      PR_VERSION:     h.elf_version = 32'hFFFF_FFFF;
      PR_MACHINE:     h.type_machine[31:16] = ~(model_cfg.machine_code_a |
                                                model_cfg.machine_code_b);
      PR_PH_EMPTY: begin
        h.ph_table[31:16] = 16'd0;
        h.ph_offset       = 32'd1;
      end
      PR_SH_EMPTY: begin
        h.sh_table[31:16] = 16'd0;
        h.sh_start        = 32'd0;
        h.sh_string_index = 16'd1;
      end
      PR_PHENT:       h.ph_table[15:0] = PHDR_BYTES - 16'd1;
      PR_PHNUM:       h.ph_table = 32'hFFFF_FFFF;
      PR_PHOFF:       h.ph_offset = h.file_size;
      PR_SHENT:       h.sh_table[15:0] = SHDR_BYTES - 16'd1;
      PR_SHNUM:       h.sh_table = 32'hFFFF_FFFF;
      PR_SHOFF:       h.sh_start = 32'(eff) - 32'd1;
      PR_STRNDX:      h.sh_string_index = h.sh_table[31:16];
      PR_ZEROS:       h = '0;
      PR_ONES:        h = '1;
      default: ;
    endcase
    return h;
  endfunction

  task automatic queue_random(int unsigned count);
    hdr_t        h;
    int unsigned roll;
    repeat (count) begin
      roll = $urandom_range(99);
      if (roll < 10) begin
        h = noise_header();
      end else begin
        h = sound_header(1'($urandom_range(1)), $urandom_range(7) == 0);
        if (roll >= 40) h = damage(h);
        if (roll >= 85) h = damage(h);
      end
      pending_hdrs.push_back(h);
    end
  endtask

  // ---------------------------------------------------------------- control

  task automatic write_reg(cfg_index_t idx, logic [31:0] val);
    @(posedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    case (idx)
      CFG_MACH_A:    model_cfg.machine_code_a = val[15:0];
      CFG_MACH_B:    model_cfg.machine_code_b = val[15:0];
      CFG_MIN_BYTES: model_cfg.min_file_bytes = val;
      CFG_OS_FLOOR:  model_cfg.os_type_floor  = val[15:0];
      default: ;
    endcase
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic load_config(logic [15:0] mach_a, logic [15:0] mach_b,
                             logic [31:0] min_bytes, logic [15:0] os_floor);
    write_reg(CFG_MACH_A, 32'(mach_a));
    write_reg(CFG_MACH_B, 32'(mach_b));
    write_reg(CFG_MIN_BYTES, min_bytes);
    write_reg(CFG_OS_FLOOR, 32'(os_floor));
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending_hdrs.size() != 0 || in_ch.valid || expected_status.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic report_mismatch(string what);
    mismatch_count++;
    $display("%0t ns  mismatch: %s", $time, what);
  endtask

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) expected_status.push_back(header_status(on_wire));
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_hdrs.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          on_wire = pending_hdrs.pop_front();
          in_ch.valid           <= 1'b1;
          in_ch.ident_bytes     <= on_wire.ident_bytes;
          in_ch.type_machine    <= on_wire.type_machine;
          in_ch.elf_version     <= on_wire.elf_version;
          in_ch.header_size     <= on_wire.header_size;
          in_ch.ph_offset       <= on_wire.ph_offset;
          in_ch.ph_table        <= on_wire.ph_table;
          in_ch.sh_start        <= on_wire.sh_start;
          in_ch.sh_table        <= on_wire.sh_table;
          in_ch.sh_string_index <= on_wire.sh_string_index;
          in_ch.header_bytes    <= on_wire.header_bytes;
          in_ch.file_size       <= on_wire.file_size;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_status.size() == 0) begin
          report_mismatch($sformatf("status %0d with no transaction outstanding",
                                    out_ch.status));
        end else begin
          oldest_status = expected_status.pop_front();
          if (out_ch.status !== oldest_status)
            report_mismatch($sformatf("status %0d, expected %0d", out_ch.status,
                                      oldest_status));
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    // register values after reset
    model_cfg = '{machine_code_a: 16'd3, machine_code_b: 16'd40,
                  min_file_bytes: 32'd52, os_type_floor: 16'hFE00};
    rst      = 1'b1;
    wr_en    = 1'b0;
    wr_index = CFG_MACH_A;
    wr_data  = '0;
    in_ch.valid           = 1'b0;
    in_ch.ident_bytes     = '0;
    in_ch.type_machine    = '0;
    in_ch.elf_version     = '0;
    in_ch.header_size     = '0;
    in_ch.ph_offset       = '0;
    in_ch.ph_table        = '0;
    in_ch.sh_start        = '0;
    in_ch.sh_table        = '0;
    in_ch.sh_string_index = '0;
    in_ch.header_bytes    = '0;
    in_ch.file_size       = '0;
    out_ch.ready          = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // one transaction per check and special case, default registers
    for (int k = 0; k < PR_COUNT; k++) pending_hdrs.push_back(probe_header(probe_t'(k)));
    drain();

    send_gap_pct   = gap_by_phase[1];
    recv_stall_pct = stall_by_phase[1];
    queue_random(120);
    drain();

    // loose setting: machine codes 0 and 0xFFFF, any type, no size floor
    load_config(16'd0, 16'hFFFF, 32'd0, 16'd0);
    send_gap_pct   = gap_by_phase[2];
    recv_stall_pct = stall_by_phase[2];
    queue_random(120);
    drain();

    // tightest setting: only full-size files pass
    load_config(16'hFFFF, 16'd0, 32'hFFFF_FFFF, 16'hFFFF);
    send_gap_pct   = gap_by_phase[3];
    recv_stall_pct = stall_by_phase[3];
    queue_random(80);
    drain();

    for (int p = 0; p < 4; p++) begin
      load_config(16'($urandom()), 16'($urandom()),
                  ($urandom_range(1) == 0) ? 32'($urandom_range(300)) : $urandom(),
                  16'($urandom()));
      send_gap_pct   = gap_by_phase[p];
      recv_stall_pct = stall_by_phase[p];
      queue_random(110);
      drain();
    end

    if (mismatch_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

[sim.f]
rtl/elfhv_pkg.sv
rtl/elfhv_if.sv
rtl/elfhv_cfg_regs.sv
rtl/elfhv_hdr_check.sv
rtl/elfhv_tbl_check.sv
rtl/elf32_header_validator_unit.sv
tb/sv/tb_elf32_header_validator_unit.sv
